FILE: hw/rtl/dsa_pkg.sv
// shared types and constants for the descriptor slot allocator
// holds field widths, operation and status codes, fsm states and payload structs
// no dependencies
package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int HANDLE_W      = 64;
  localparam int STEP_W        = 16;
  localparam int SLOT_COUNT_W  = 11;
  localparam int SLOT_W        = 10;
  localparam int DIV_BITS      = 4;
  localparam int CFG_IDX_W     = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REBUILD = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE    = 2'd0,
    CFG_GPU_BASE    = 2'd1,
    CFG_HANDLE_STEP = 2'd2,
    CFG_SLOT_COUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_FREE_DIV,
    S_REBUILD,
    S_RESULT
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [HANDLE_W-1:0]  cpu_handle_in;
    logic [HANDLE_W-1:0]  gpu_handle_in;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  cpu_handle_out;
    logic [HANDLE_W-1:0]  gpu_handle_out;
    logic [SLOT_W-1:0]    slot_index;
    status_t              status;
  } rsp_t;

endpackage

FILE: hw/rtl/dsa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dsa_divider.sv
// iterative unsigned divider, handle offset by handle step, several quotient bits a cycle
// depends on dsa_pkg
module dsa_divider
  import dsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [HANDLE_W-1:0] dividend,
  input  logic [STEP_W-1:0]   divisor,
  output logic                done,
  output logic [HANDLE_W-1:0] quotient
);

  localparam int STEPS = HANDLE_W / DIV_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic                busy;
  logic [CNT_W-1:0]    count;
  logic [STEP_W-1:0]   rem;
  logic [STEP_W-1:0]   div_q;
  logic [HANDLE_W-1:0] work;
  logic [STEP_W-1:0]   rem_next;
  logic [HANDLE_W-1:0] work_next;

  // dividend bits shift out the top, quotient bits shift in at the bottom
  always_comb begin
    logic [STEP_W:0] trial;
    rem_next  = rem;
    work_next = work;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial     = {rem_next, work_next[HANDLE_W-1]};
      work_next = {work_next[HANDLE_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_next     = STEP_W'(trial - {1'b0, div_q});
        work_next[0] = 1'b1;
      end else begin
        rem_next = trial[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

FILE: hw/rtl/descriptor_slot_allocator.sv
// Descriptor slot allocator: a LIFO of free slot indices kept in a synchronous RAM of
// MAX_SLOTS entries, with one transaction in flight at a time. Alloc runs RAM read, index
// times step, base add and result load; free waits on two 64-bit dividers retiring 4
// quotient bits a cycle; rebuild writes n entries, where n is slot_count limited to
// MAX_SLOTS, one at a time since the RAM takes one write a cycle; clear goes straight to
// the result. No clearing pass is needed after reset: only entries below the fill count
// are read. A finished result waits in the output register while the next request is taken.
// depends on dsa_pkg, dsa_ram, dsa_divider
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HANDLE_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int FILL_W = $clog2(MAX_SLOTS + 1);
  localparam int PROD_W = IDX_W + STEP_W;

  state_t state, state_next;

  logic [HANDLE_W-1:0]     cpu_base;
  logic [HANDLE_W-1:0]     gpu_base;
  logic [STEP_W-1:0]       handle_step;
  logic [SLOT_COUNT_W-1:0] slot_count;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] rb_left;
  logic [FILL_W-1:0] usable;
  logic [IDX_W-1:0]  alloc_idx;
  logic [PROD_W-1:0] prod;
  rsp_t              pend;

  logic              accept;
  logic              out_free;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;

  logic                div_start;
  logic                cpu_done;
  logic                gpu_done;
  logic [HANDLE_W-1:0] cpu_quo;
  logic [HANDLE_W-1:0] gpu_quo;

  logic     stack_full;
  logic     free_ok;
  status_t  free_status;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign usable   = (32'(slot_count) > 32'(MAX_SLOTS)) ? FILL_W'(MAX_SLOTS)
                                                       : FILL_W'(slot_count);
  assign stack_full = (32'(fill) >= 32'(MAX_SLOTS));

  // mismatch is checked before range, range before full
  always_comb begin
    if (cpu_quo != gpu_quo) begin
      free_status = ST_MISMATCH;
    end else if (cpu_quo >= HANDLE_W'(usable)) begin
      free_status = ST_RANGE;
    end else if (stack_full) begin
      free_status = ST_FULL;
    end else begin
      free_status = ST_OK;
    end
  end
  assign free_ok = (free_status == ST_OK);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base    <= '0;
      gpu_base    <= '0;
      handle_step <= STEP_RESET;
      slot_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CPU_BASE:    cpu_base    <= cfg_data;
        CFG_GPU_BASE:    gpu_base    <= cfg_data;
        CFG_HANDLE_STEP: handle_step <= cfg_data[STEP_W-1:0];
        CFG_SLOT_COUNT:  slot_count  <= cfg_data[SLOT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_data.mode)
            MODE_ALLOC:   state_next = (fill == '0) ? S_RESULT : S_ALLOC_MUL;
            MODE_FREE:    state_next = (handle_step == '0) ? S_RESULT : S_FREE_DIV;
            MODE_REBUILD: state_next = (usable == '0) ? S_RESULT : S_REBUILD;
            MODE_CLEAR:   state_next = S_RESULT;
            default:      state_next = S_RESULT;
          endcase
        end
      end
      S_ALLOC_MUL: state_next = S_ALLOC_ADD;
      S_ALLOC_ADD: state_next = S_RESULT;
      S_FREE_DIV: begin
        if (cpu_done) begin
          state_next = S_RESULT;
        end
      end
      S_REBUILD: begin
        if (rb_left == FILL_W'(1)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the fsm
  always_comb begin
    req_stall = (state != S_IDLE);
    cfg_ready = (state == S_IDLE);
    ram_re    = 1'b0;
    ram_raddr = IDX_W'(fill - FILL_W'(1));
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(fill);
    ram_wdata = cpu_quo[IDX_W-1:0];
    div_start = 1'b0;
    case (state)
      S_IDLE: begin
        ram_re    = accept && (req_data.mode == MODE_ALLOC) && (fill != '0);
        div_start = accept && (req_data.mode == MODE_FREE) && (handle_step != '0);
      end
      S_FREE_DIV: begin
        ram_we = cpu_done && free_ok;
      end
      S_REBUILD: begin
        // entry k gets n-1-k, so slot 0 ends on top
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(fill - rb_left);
        ram_wdata = IDX_W'(rb_left - FILL_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rb_left   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESULT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req_data.mode == MODE_REBUILD)) begin
            fill    <= usable;
            rb_left <= usable;
          end else if (accept && (req_data.mode == MODE_CLEAR)) begin
            fill <= '0;
          end
        end
        S_ALLOC_MUL: fill <= fill - FILL_W'(1);
        S_FREE_DIV: begin
          if (cpu_done && free_ok) begin
            fill <= fill + FILL_W'(1);
          end
        end
        S_REBUILD: rb_left <= rb_left - FILL_W'(1);
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          pend.cpu_handle_out <= '0;
          pend.gpu_handle_out <= '0;
          pend.slot_index     <= '0;
          if (req_data.mode == MODE_ALLOC && fill == '0) begin
            pend.status <= ST_EMPTY;
          end else if (req_data.mode == MODE_FREE && handle_step == '0) begin
            pend.status <= ST_RANGE;
          end else begin
            pend.status <= ST_OK;
          end
        end
      end
      S_ALLOC_MUL: begin
        alloc_idx <= ram_rdata;
        prod      <= PROD_W'(ram_rdata) * PROD_W'(handle_step);
      end
      S_ALLOC_ADD: begin
        pend.cpu_handle_out <= cpu_base + HANDLE_W'(prod);
        pend.gpu_handle_out <= gpu_base + HANDLE_W'(prod);
        pend.slot_index     <= SLOT_W'(alloc_idx);
        pend.status         <= ST_OK;
      end
      S_FREE_DIV: begin
        if (cpu_done) begin
          pend.status     <= free_status;
          pend.slot_index <= free_ok ? cpu_quo[SLOT_W-1:0] : '0;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          rsp_data <= pend;
        end
      end
      default: ;
    endcase
  end

  dsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsa_divider u_cpu_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_data.cpu_handle_in - cpu_base),
    .divisor  (handle_step),
    .done     (cpu_done),
    .quotient (cpu_quo)
  );

  dsa_divider u_gpu_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_data.gpu_handle_in - gpu_base),
    .divisor  (handle_step),
    .done     (gpu_done),
    .quotient (gpu_quo)
  );

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    cpu_done == gpu_done)
    else $error("dividers out of step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(MAX_SLOTS))
    else $error("stack fill beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("second transaction taken while one is in flight");

  a_ram_port_use: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("stack read and write in the same cycle");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("response raised outside result state");
`endif

endmodule
